// ===== hdl/tcq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcq_pkg
// Shared types and constants of the touch contact qualifier: request codes,
// contact state codes, register map, reset values and inter-module structs.
// ----------------------------------------------------------------------------
package tcq_pkg;

    localparam int unsigned CoordW   = 12;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned TimeoutW = 16;
    localparam int unsigned AddrW    = 5;
    localparam int unsigned DataW    = 32;
    localparam int unsigned RegIdxW  = 3;

    // Request codes carried by req_type.
    localparam logic [1:0] ReqPoint = 2'd0;
    localparam logic [1:0] ReqPoll  = 2'd1;
    localparam logic [1:0] ReqRead  = 2'd2;

    // Contact state codes as reported on contact_state.
    localparam logic [1:0] CsNone = 2'd0;
    localparam logic [1:0] CsDown = 2'd1;
    localparam logic [1:0] CsUp   = 2'd2;

    // Register indexes; the byte address is four times the index.
    localparam logic [RegIdxW-1:0] RegXLimit  = 3'd0;
    localparam logic [RegIdxW-1:0] RegYLimit  = 3'd1;
    localparam logic [RegIdxW-1:0] RegSwap    = 3'd2;
    localparam logic [RegIdxW-1:0] RegMirrorX = 3'd3;
    localparam logic [RegIdxW-1:0] RegMirrorY = 3'd4;
    localparam logic [RegIdxW-1:0] RegTimeout = 3'd5;

    // Register reset values.
    localparam logic [CoordW-1:0]   XLimitRst  = 12'd800;
    localparam logic [CoordW-1:0]   YLimitRst  = 12'd600;
    localparam logic [TimeoutW-1:0] TimeoutRst = 16'd200;

    typedef struct packed {
        logic [CoordW-1:0]   x_limit;
        logic [CoordW-1:0]   y_limit;
        logic                swap_axes;
        logic                mirror_x;
        logic                mirror_y;
        logic [TimeoutW-1:0] release_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic              pressure;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic              dropped;
    } t_sample;

    typedef struct packed {
        logic              report_valid;
        logic              report_pressure;
        logic [CoordW-1:0] report_x;
        logic [CoordW-1:0] report_y;
        logic [1:0]        contact_state;
        logic              sample_dropped;
    } t_result;

endpackage

// ===== hdl/tcq_regs.sv =====
// ----------------------------------------------------------------------------
// tcq_regs
// Configuration registers behind the APB-style port, with read-back.
// ----------------------------------------------------------------------------
module tcq_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcq_pkg::AddrW-1:0]   paddr,
    input  logic [tcq_pkg::DataW-1:0]   pwdata,
    output logic [tcq_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    output tcq_pkg::t_cfg               o_cfg
);

    tcq_pkg::t_cfg                  r_cfg;
    logic                           wr_en;
    logic [tcq_pkg::RegIdxW-1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[tcq_pkg::AddrW-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_limit            <= tcq_pkg::XLimitRst;
            r_cfg.y_limit            <= tcq_pkg::YLimitRst;
            r_cfg.swap_axes          <= 1'b0;
            r_cfg.mirror_x           <= 1'b1;
            r_cfg.mirror_y           <= 1'b0;
            r_cfg.release_timeout_ms <= tcq_pkg::TimeoutRst;
        end else if (wr_en) begin
            unique case (reg_idx)
                tcq_pkg::RegXLimit:  r_cfg.x_limit   <= pwdata[tcq_pkg::CoordW-1:0];
                tcq_pkg::RegYLimit:  r_cfg.y_limit   <= pwdata[tcq_pkg::CoordW-1:0];
                tcq_pkg::RegSwap:    r_cfg.swap_axes <= pwdata[0];
                tcq_pkg::RegMirrorX: r_cfg.mirror_x  <= pwdata[0];
                tcq_pkg::RegMirrorY: r_cfg.mirror_y  <= pwdata[0];
                tcq_pkg::RegTimeout: begin
                    r_cfg.release_timeout_ms <= pwdata[tcq_pkg::TimeoutW-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            tcq_pkg::RegXLimit:  prdata[tcq_pkg::CoordW-1:0] = r_cfg.x_limit;
            tcq_pkg::RegYLimit:  prdata[tcq_pkg::CoordW-1:0] = r_cfg.y_limit;
            tcq_pkg::RegSwap:    prdata[0] = r_cfg.swap_axes;
            tcq_pkg::RegMirrorX: prdata[0] = r_cfg.mirror_x;
            tcq_pkg::RegMirrorY: prdata[0] = r_cfg.mirror_y;
            tcq_pkg::RegTimeout: prdata[tcq_pkg::TimeoutW-1:0] = r_cfg.release_timeout_ms;
            default: ;
        endcase
    end

endmodule

// ===== hdl/tcq_decode.sv =====
// ----------------------------------------------------------------------------
// tcq_decode
// Point record decode: status, coordinates, range check, swap and mirroring.
// ----------------------------------------------------------------------------
module tcq_decode (
    input  logic [7:0]      i_rec_byte0,
    input  logic [7:0]      i_rec_byte1,
    input  logic [7:0]      i_rec_byte2,
    input  logic [7:0]      i_rec_byte3,
    input  logic            i_fsm_down,
    input  tcq_pkg::t_cfg   i_cfg,
    output tcq_pkg::t_sample o_sample
);

    logic                       touching;
    logic                       pressure;
    logic [tcq_pkg::CoordW-1:0] raw_x;
    logic [tcq_pkg::CoordW-1:0] raw_y;
    logic [tcq_pkg::CoordW-1:0] sw_x;
    logic [tcq_pkg::CoordW-1:0] sw_y;

    // Status codes with bit 6 clear mean the finger is on the panel.
    assign touching = ~i_rec_byte0[6];
    // A lift status only counts as a release while a contact is down.
    assign pressure = touching | ~i_fsm_down;
    assign raw_x    = pressure ? {i_rec_byte0[3:0], i_rec_byte1} : '0;
    assign raw_y    = pressure ? {i_rec_byte2[3:0], i_rec_byte3} : '0;
    assign sw_x     = i_cfg.swap_axes ? raw_y : raw_x;
    assign sw_y     = i_cfg.swap_axes ? raw_x : raw_y;

    always_comb begin
        o_sample.pressure = pressure;
        o_sample.dropped  = (raw_x > i_cfg.x_limit) | (raw_y > i_cfg.y_limit);
        o_sample.x        = sw_x;
        o_sample.y        = sw_y;
        if (pressure && i_cfg.mirror_x) begin
            o_sample.x = (i_cfg.x_limit >= sw_x) ? i_cfg.x_limit - sw_x : '0;
        end
        if (pressure && i_cfg.mirror_y) begin
            o_sample.y = (i_cfg.y_limit >= sw_y) ? i_cfg.y_limit - sw_y : '0;
        end
    end

endmodule

// ===== hdl/tcq_core.sv =====
// ----------------------------------------------------------------------------
// tcq_core
// Contact state machine, latched report and release timer; forms the result.
// ----------------------------------------------------------------------------
module tcq_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [1:0]                  i_req_type,
    input  tcq_pkg::t_sample            i_sample,
    input  logic                        i_line_high,
    input  logic [tcq_pkg::TimeW-1:0]   i_time_ms,
    input  tcq_pkg::t_cfg               i_cfg,
    output logic                        o_fsm_down,
    output tcq_pkg::t_result            o_result
);

    typedef enum logic [2:0] {
        S_NONE = 3'b001,
        S_DOWN = 3'b010,
        S_UP   = 3'b100
    } t_state;

    t_state                         r_fsm, n_fsm;
    logic                           r_active, n_active;
    logic                           r_frs, n_frs;
    logic                           r_held_p, n_held_p;
    logic [tcq_pkg::CoordW-1:0]     r_held_x, n_held_x;
    logic [tcq_pkg::CoordW-1:0]     r_held_y, n_held_y;
    logic                           r_armed, n_armed;
    logic [tcq_pkg::TimeW-1:0]      r_start, n_start;
    logic [tcq_pkg::TimeW-1:0]      start_ms;
    logic [tcq_pkg::TimeW-1:0]      dur_ms;
    logic                           upd;

    assign o_fsm_down = (r_fsm == S_DOWN);
    assign start_ms   = r_armed ? r_start : i_time_ms;
    assign dur_ms     = i_time_ms - start_ms;

    always_comb begin
        n_fsm    = r_fsm;
        n_active = r_active;
        n_frs    = r_frs;
        n_held_p = r_held_p;
        n_held_x = r_held_x;
        n_held_y = r_held_y;
        n_armed  = r_armed;
        n_start  = r_start;
        upd      = 1'b0;
        o_result = '0;

        unique case (i_req_type)
            tcq_pkg::ReqPoint: begin
                n_armed = 1'b0;
                o_result.sample_dropped = i_sample.dropped;
                if (!i_sample.dropped) begin
                    unique case (r_fsm)
                        S_NONE: begin
                            if (i_sample.pressure) begin
                                n_fsm    = S_DOWN;
                                n_active = 1'b1;
                                n_frs    = 1'b0;
                                upd      = 1'b1;
                            end
                        end
                        S_DOWN: begin
                            if (!i_sample.pressure) begin
                                n_fsm = S_UP;
                            end
                            upd = r_frs;
                        end
                        default: begin
                            if (!i_sample.pressure) begin
                                n_fsm    = S_NONE;
                                n_active = 1'b0;
                            end else begin
                                n_fsm    = S_DOWN;
                                n_active = 1'b1;
                                upd      = 1'b1;
                            end
                        end
                    endcase
                    if (upd) begin
                        n_held_p = i_sample.pressure;
                        n_held_x = i_sample.x;
                        n_held_y = i_sample.y;
                    end
                end
            end
            tcq_pkg::ReqPoll: begin
                if (r_fsm == S_UP && r_frs) begin
                    n_fsm    = S_NONE;
                    n_active = 1'b0;
                    n_held_p = 1'b0;
                    n_held_x = '0;
                    n_held_y = '0;
                end
                if (r_fsm == S_DOWN && i_line_high) begin
                    n_start = start_ms;
                    n_armed = 1'b1;
                    if (dur_ms > {{(tcq_pkg::TimeW-tcq_pkg::TimeoutW){1'b0}},
                                  i_cfg.release_timeout_ms} && r_frs) begin
                        n_fsm    = S_UP;
                        n_active = 1'b0;
                        n_held_p = 1'b0;
                        n_held_x = '0;
                        n_held_y = '0;
                    end
                end
            end
            tcq_pkg::ReqRead: begin
                if (r_active) begin
                    o_result.report_valid    = 1'b1;
                    o_result.report_pressure = r_held_p;
                    o_result.report_x        = r_held_x;
                    o_result.report_y        = r_held_y;
                    if (r_held_p) begin
                        n_frs = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        unique case (n_fsm)
            S_DOWN:  o_result.contact_state = tcq_pkg::CsDown;
            S_UP:    o_result.contact_state = tcq_pkg::CsUp;
            default: o_result.contact_state = tcq_pkg::CsNone;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= S_NONE;
            r_active <= 1'b0;
            r_frs    <= 1'b0;
            r_held_p <= 1'b0;
            r_held_x <= '0;
            r_held_y <= '0;
            r_armed  <= 1'b0;
            r_start  <= '0;
        end else if (i_fire) begin
            r_fsm    <= n_fsm;
            r_active <= n_active;
            r_frs    <= n_frs;
            r_held_p <= n_held_p;
            r_held_x <= n_held_x;
            r_held_y <= n_held_y;
            r_armed  <= n_armed;
            r_start  <= n_start;
        end
    end

endmodule

// ===== hdl/touch_contact_qualifier.sv =====
// Path: an accepted item is held in the input register, and its result in the result register.
// Throughput: one item per cycle; the input register refills whenever the result register
// is empty or being taken, so only output back-pressure slows the block down.
// Reset: synchronous, active low; the contact machine, report latch and timer clear and the
// configuration registers return to their documented defaults.
// ----------------------------------------------------------------------------
// touch_contact_qualifier
// Qualifies single-point touch contacts. Point records are decoded, range checked,
// optionally swapped and mirrored, and drive a none/down/up contact machine. Idle
// polls force releases, and report reads return the latched coordinates.
// ----------------------------------------------------------------------------
module touch_contact_qualifier (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    // Input item channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_req_type,
    input  logic [7:0]                  i_rec_byte0,
    input  logic [7:0]                  i_rec_byte1,
    input  logic [7:0]                  i_rec_byte2,
    input  logic [7:0]                  i_rec_byte3,
    input  logic                        i_line_high,
    input  logic [tcq_pkg::TimeW-1:0]   i_time_ms,

    // Result item channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_report_valid,
    output logic                        o_report_pressure,
    output logic [tcq_pkg::CoordW-1:0]  o_report_x,
    output logic [tcq_pkg::CoordW-1:0]  o_report_y,
    output logic [1:0]                  o_contact_state,
    output logic                        o_sample_dropped,

    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcq_pkg::AddrW-1:0]   paddr,
    input  logic [tcq_pkg::DataW-1:0]   pwdata,
    output logic [tcq_pkg::DataW-1:0]   prdata,
    output logic                        pready
);

    // Input register: holds one accepted item until the core consumes it.
    logic                           r_in_vld;
    logic [1:0]                     r_req_type;
    logic [7:0]                     r_b0, r_b1, r_b2, r_b3;
    logic                           r_line_high;
    logic [tcq_pkg::TimeW-1:0]      r_time_ms;

    // Result register.
    logic                           r_out_vld;
    tcq_pkg::t_result               r_res;

    tcq_pkg::t_cfg                  cfg;
    tcq_pkg::t_sample               sample;
    tcq_pkg::t_result               result;
    logic                           fsm_down;
    logic                           advance;
    logic                           in_fire;

    // The held item moves into the result register when that slot is free or being
    // emptied in the same cycle; the input register refills in that same cycle.
    assign advance    = r_in_vld & (~r_out_vld | i_out_ready);
    assign o_in_ready = ~r_in_vld | advance;
    assign in_fire    = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req_type  <= i_req_type;
            r_b0        <= i_rec_byte0;
            r_b1        <= i_rec_byte1;
            r_b2        <= i_rec_byte2;
            r_b3        <= i_rec_byte3;
            r_line_high <= i_line_high;
            r_time_ms   <= i_time_ms;
        end
    end

    tcq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Decode looks at the current contact state, since a lift status only means
    // a release while a contact is down.
    tcq_decode u_decode (
        .i_rec_byte0 (r_b0),
        .i_rec_byte1 (r_b1),
        .i_rec_byte2 (r_b2),
        .i_rec_byte3 (r_b3),
        .i_fsm_down  (fsm_down),
        .i_cfg       (cfg),
        .o_sample    (sample)
    );

    // The core state commits in the same cycle that the result is registered,
    // so the next item already sees the updated state.
    tcq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_req_type  (r_req_type),
        .i_sample    (sample),
        .i_line_high (r_line_high),
        .i_time_ms   (r_time_ms),
        .i_cfg       (cfg),
        .o_fsm_down  (fsm_down),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= result;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_report_valid    = r_res.report_valid;
    assign o_report_pressure = r_res.report_pressure;
    assign o_report_x        = r_res.report_x;
    assign o_report_y        = r_res.report_y;
    assign o_contact_state   = r_res.contact_state;
    assign o_sample_dropped  = r_res.sample_dropped;

endmodule
